// ===== sv/sbx_pkg.sv =====
// Shared types, codes and sizes of the stack bytecode execute unit.
`default_nettype none
package sbx_pkg;

	// Stack sizes and the derived address widths.
	localparam int DS_DEPTH = 256;
	localparam int DS_AW    = 8;
	localparam int SP_W     = 9;
	localparam int RS_DEPTH = 64;
	localparam int RS_AW    = 6;
	localparam int RP_W     = 7;
	localparam int PC_W     = 16;

	// Opcodes.
	localparam logic [7:0] OP_CALL = 8'd0;
	localparam logic [7:0] OP_RET  = 8'd1;
	localparam logic [7:0] OP_HALT = 8'd2;
	localparam logic [7:0] OP_PUSH = 8'd3;
	localparam logic [7:0] OP_POP  = 8'd4;
	localparam logic [7:0] OP_FLD  = 8'd5;
	localparam logic [7:0] OP_IMM  = 8'd6;
	localparam logic [7:0] OP_MLD  = 8'd7;
	localparam logic [7:0] OP_MST  = 8'd8;
	localparam logic [7:0] OP_FST  = 8'd9;
	localparam logic [7:0] OP_JZ   = 8'd10;
	localparam logic [7:0] OP_DISC = 8'd11;
	localparam logic [7:0] OP_JMP  = 8'd12;
	localparam logic [7:0] OP_JNZ  = 8'd13;

	// Intrinsic numbers.
	localparam logic [31:0] IN_ADD = 32'd1;
	localparam logic [31:0] IN_SUB = 32'd2;
	localparam logic [31:0] IN_DIV = 32'd3;
	localparam logic [31:0] IN_MUL = 32'd4;
	localparam logic [31:0] IN_MOD = 32'd5;
	localparam logic [31:0] IN_PRN = 32'd6;
	localparam logic [31:0] IN_NL  = 32'd7;
	localparam logic [31:0] IN_EQ  = 32'd8;
	localparam logic [31:0] IN_RDN = 32'd9;
	localparam logic [31:0] IN_NOT = 32'd22;
	localparam logic [31:0] IN_LT  = 32'd23;
	localparam logic [31:0] IN_GT  = 32'd24;

	// Classes that the front hands to the back.
	localparam logic [4:0] CL_ADD   = 5'd0;
	localparam logic [4:0] CL_SUB   = 5'd1;
	localparam logic [4:0] CL_DIV   = 5'd2;
	localparam logic [4:0] CL_MUL   = 5'd3;
	localparam logic [4:0] CL_MOD   = 5'd4;
	localparam logic [4:0] CL_EQ    = 5'd5;
	localparam logic [4:0] CL_LT    = 5'd6;
	localparam logic [4:0] CL_GT    = 5'd7;
	localparam logic [4:0] CL_PRN   = 5'd8;
	localparam logic [4:0] CL_NOT   = 5'd9;
	localparam logic [4:0] CL_NL    = 5'd10;
	localparam logic [4:0] CL_RDN   = 5'd11;
	localparam logic [4:0] CL_UNSUP = 5'd12;
	localparam logic [4:0] CL_CALL  = 5'd13;
	localparam logic [4:0] CL_RET   = 5'd14;
	localparam logic [4:0] CL_HALT  = 5'd15;
	localparam logic [4:0] CL_PUSH  = 5'd16;
	localparam logic [4:0] CL_POP   = 5'd17;
	localparam logic [4:0] CL_FLD   = 5'd18;
	localparam logic [4:0] CL_IMM   = 5'd19;
	localparam logic [4:0] CL_MLD   = 5'd20;
	localparam logic [4:0] CL_MST   = 5'd21;
	localparam logic [4:0] CL_FST   = 5'd22;
	localparam logic [4:0] CL_JZ    = 5'd23;
	localparam logic [4:0] CL_DISC  = 5'd24;
	localparam logic [4:0] CL_JMP   = 5'd25;
	localparam logic [4:0] CL_JNZ   = 5'd26;
	localparam logic [4:0] CL_BAD   = 5'd27;

	// Error codes.
	localparam logic [2:0] ERR_OK    = 3'd0;
	localparam logic [2:0] ERR_OPC   = 3'd1;
	localparam logic [2:0] ERR_UNSUP = 3'd2;
	localparam logic [2:0] ERR_OVER  = 3'd3;
	localparam logic [2:0] ERR_UNDER = 3'd4;
	localparam logic [2:0] ERR_DIV0  = 3'd5;
	localparam logic [2:0] ERR_INDEX = 3'd6;

	// Print kinds.
	localparam logic [1:0] PK_NONE = 2'd0;
	localparam logic [1:0] PK_NUM  = 2'd1;
	localparam logic [1:0] PK_NL   = 2'd2;

	typedef struct packed {
		logic [7:0]         req_type;
		logic signed [31:0] operand_word;
		logic [7:0]         operand_byte;
		logic signed [31:0] load_word;
		logic signed [31:0] console_number;
	} req_t;

	typedef struct packed {
		logic [15:0]        next_pc;
		logic               mem_write;
		logic [15:0]        mem_addr;
		logic signed [31:0] mem_data;
		logic [1:0]         print_kind;
		logic signed [31:0] print_value;
		logic               halted;
		logic [7:0]         exit_code;
		logic [2:0]         error_code;
	} res_t;

	// Classified item held in the queue between front and back.
	typedef struct packed {
		logic [4:0]  cls;
		logic [31:0] word;
		logic [7:0]  xbyte;
		logic [31:0] load;
		logic [31:0] cons;
	} dec_t;

	// Number of data stack reads a class needs before it executes.
	function automatic logic [1:0] reads_of(input logic [4:0] cls);
		logic [1:0] n;
		case (cls)
			CL_ADD, CL_SUB, CL_DIV, CL_MUL, CL_MOD, CL_EQ, CL_LT, CL_GT: n = 2'd2;
			CL_PRN, CL_NOT, CL_RET, CL_POP, CL_FLD: n = 2'd1;
			default: n = 2'd0;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

// ===== sv/stack_bytecode_execute_unit.sv =====
// Top level of the stack bytecode execute unit.
//
//   Channel   Handshake        Payload
//   input     push / full      req (sbx_pkg::req_t)
//   result    pop / empty      res (sbx_pkg::res_t)
//
// Each item gives exactly one result. After the front queue, an item passes
// in the back end through the data stack read states it needs (one registered
// memory read each) and the execute state; divide and modulo then wait for the
// one-bit-per-cycle divider, and a stopped machine answers from the idle state.
// Reset clears the registers; the stack memories are not cleared. A full
// result register holds the back end, and a full two-entry queue holds the input.
`default_nettype none
module stack_bytecode_execute_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire sbx_pkg::req_t req,
	output logic               empty,
	input  wire logic          pop,
	output sbx_pkg::res_t      res
);
	import sbx_pkg::*;

	logic q_valid, q_pop;
	dec_t q_item;

	sbx_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.req     (req),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	sbx_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.res     (res)
	);

endmodule
`default_nettype wire

// ===== sv/sbx_front.sv =====
// Front end: accepts items, classifies them and queues them for the back end.
`default_nettype none
module sbx_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire sbx_pkg::req_t req,
	output logic               q_valid,
	output sbx_pkg::dec_t      q_item,
	input  wire logic          q_pop
);
	import sbx_pkg::*;

	dec_t       fifo_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	dec_t       dec;
	logic [31:0] k;
	logic       do_push, do_pop;

	// Classify the opcode and, for calls with a negative operand, the intrinsic.
	always_comb begin
		k = 32'd0 - req.operand_word;
		dec.word  = req.operand_word;
		dec.xbyte = req.operand_byte;
		dec.load  = req.load_word;
		dec.cons  = req.console_number;
		case (req.req_type)
			OP_CALL: begin
				if (req.operand_word[31]) begin
					case (k)
						IN_ADD:  dec.cls = CL_ADD;
						IN_SUB:  dec.cls = CL_SUB;
						IN_DIV:  dec.cls = CL_DIV;
						IN_MUL:  dec.cls = CL_MUL;
						IN_MOD:  dec.cls = CL_MOD;
						IN_PRN:  dec.cls = CL_PRN;
						IN_NL:   dec.cls = CL_NL;
						IN_EQ:   dec.cls = CL_EQ;
						IN_RDN:  dec.cls = CL_RDN;
						IN_NOT:  dec.cls = CL_NOT;
						IN_LT:   dec.cls = CL_LT;
						IN_GT:   dec.cls = CL_GT;
						default: dec.cls = CL_UNSUP;
					endcase
				end else begin
					dec.cls = CL_CALL;
				end
			end
			OP_RET:  dec.cls = CL_RET;
			OP_HALT: dec.cls = CL_HALT;
			OP_PUSH: dec.cls = CL_PUSH;
			OP_POP:  dec.cls = CL_POP;
			OP_FLD:  dec.cls = CL_FLD;
			OP_IMM:  dec.cls = CL_IMM;
			OP_MLD:  dec.cls = CL_MLD;
			OP_MST:  dec.cls = CL_MST;
			OP_FST:  dec.cls = CL_FST;
			OP_JZ:   dec.cls = CL_JZ;
			OP_DISC: dec.cls = CL_DISC;
			OP_JMP:  dec.cls = CL_JMP;
			OP_JNZ:  dec.cls = CL_JNZ;
			default: dec.cls = CL_BAD;
		endcase
	end

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = fifo_q[rp_q];
	assign do_push = push && !full;
	assign do_pop  = q_pop && q_valid;

	// Two-entry queue storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wp_q] <= dec;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= !wp_q;
			end
			if (do_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule
`default_nettype wire

// ===== sv/sbx_div.sv =====
// Iterative signed divider: one quotient bit per cycle.
`default_nettype none
module sbx_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic             done,
	output logic [31:0]      quot,
	output logic [31:0]      rem
);
	logic [5:0]  cnt_q;
	logic        run_q, done_q, nq_q, nr_q;
	logic [31:0] r_q, q_q, d_q;
	logic [32:0] trial;
	logic [31:0] shifted;

	// Shift in the next dividend bit and try to subtract the divisor.
	assign shifted = {r_q[30:0], q_q[31]};
	assign trial   = {r_q[31], shifted} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 6'd0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
			nq_q   <= 1'b0;
			nr_q   <= 1'b0;
			r_q    <= 32'd0;
			q_q    <= 32'd0;
			d_q    <= 32'd0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				r_q   <= 32'd0;
				q_q   <= a[31] ? 32'd0 - a : a;
				d_q   <= b[31] ? 32'd0 - b : b;
				nq_q  <= a[31] ^ b[31];
				nr_q  <= a[31];
				cnt_q <= 6'd32;
				run_q <= 1'b1;
			end else if (run_q) begin
				if (!trial[32]) begin
					r_q <= trial[31:0];
				end else begin
					r_q <= shifted;
				end
				q_q   <= {q_q[30:0], !trial[32]};
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = nq_q ? 32'd0 - q_q : q_q;
	assign rem  = nr_q ? 32'd0 - r_q : r_q;

endmodule
`default_nettype wire

// ===== sv/sbx_back.sv =====
// Back end: owns the machine state and stacks and executes classified items.
`default_nettype none
module sbx_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  wire sbx_pkg::dec_t q_item,
	output logic               q_pop,
	output logic               empty,
	input  wire logic          pop,
	output sbx_pkg::res_t      res
);
	import sbx_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_RD2  = 3'd2;
	localparam logic [2:0] ST_EXE  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;

	logic [2:0]      state_q;
	dec_t            cur_q;
	logic [31:0]     acc_q, opa_q, opb_q;
	logic [PC_W-1:0] pc_q;
	logic [SP_W-1:0] fb_q, sp_q;
	logic [RP_W-1:0] rsp_q;
	logic            stop_q;
	res_t            res_q;
	logic            res_vld_q;

	logic [31:0]     ds_mem [DS_DEPTH];
	logic [PC_W-1:0] rs_mem [RS_DEPTH];
	logic [31:0]     ds_rd_q;
	logic [PC_W-1:0] rs_rd_q;
	logic [DS_AW-1:0] ds_raddr;
	logic [RS_AW-1:0] rs_raddr;

	logic            start;
	logic [PC_W-1:0] pc1, pc2, pc5, tgt;
	logic signed [33:0] idx;
	logic            idx_bad;

	// Execute results.
	logic [2:0]      err;
	logic [PC_W-1:0] npc;
	logic [31:0]     acc_n;
	logic [SP_W-1:0] sp_n, fb_n;
	logic [RP_W-1:0] rsp_n;
	logic            halt_n;
	logic            ds_we_x, rs_we_x, ds_we, rs_we, div_go;
	logic [DS_AW-1:0] ds_wa;
	logic [31:0]     ds_wd;
	res_t            res_x, res_stop, res_div;

	logic            div_done;
	logic [31:0]     quot, rem;

	assign start = (state_q == ST_IDLE) && q_valid && (!res_vld_q || pop);
	assign q_pop = start;
	assign empty = !res_vld_q;
	assign res   = res_q;

	assign pc1 = pc_q + 16'd1;
	assign pc2 = pc_q + 16'd2;
	assign pc5 = pc_q + 16'd5;
	assign tgt = cur_q.word[PC_W-1:0];

	// Frame index: frame base plus operand minus one, in range only below the depth.
	assign idx = $signed({25'd0, fb_q}) + $signed({{2{cur_q.word[31]}}, cur_q.word})
		- 34'sd1;
	assign idx_bad = (idx[33:DS_AW] != '0);

	// Data stack read address: first read comes from the new item, second is below top.
	always_comb begin
		if (state_q == ST_IDLE) begin
			case (q_item.cls)
				CL_RET:  ds_raddr = DS_AW'(fb_q - 9'd1);
				CL_FLD:  ds_raddr = DS_AW'(fb_q) + q_item.word[DS_AW-1:0] - 8'd1;
				default: ds_raddr = DS_AW'(sp_q - 9'd1);
			endcase
		end else begin
			ds_raddr = DS_AW'(sp_q - 9'd2);
		end
		rs_raddr = RS_AW'(rsp_q - 7'd1);
	end

	// Execute step of one item.
	always_comb begin
		err     = ERR_OK;
		npc     = pc5;
		acc_n   = acc_q;
		sp_n    = sp_q;
		fb_n    = fb_q;
		rsp_n   = rsp_q;
		halt_n  = 1'b0;
		ds_we_x = 1'b0;
		rs_we_x = 1'b0;
		ds_wa   = DS_AW'(sp_q);
		ds_wd   = acc_q;
		div_go  = 1'b0;
		res_x   = '0;
		case (cur_q.cls)
			CL_ADD, CL_SUB, CL_MUL, CL_EQ, CL_LT, CL_GT: begin
				if (sp_q < 9'd2) begin
					err = ERR_UNDER;
				end else begin
					sp_n = sp_q - 9'd2;
					case (cur_q.cls)
						CL_ADD:  acc_n = opa_q + opb_q;
						CL_SUB:  acc_n = opa_q - opb_q;
						CL_MUL:  acc_n = opa_q * opb_q;
						CL_EQ:   acc_n = {31'd0, opa_q == opb_q};
						CL_LT:   acc_n = {31'd0, $signed(opa_q) < $signed(opb_q)};
						default: acc_n = {31'd0, $signed(opa_q) > $signed(opb_q)};
					endcase
				end
			end
			CL_DIV, CL_MOD: begin
				if (sp_q < 9'd2) begin
					err = ERR_UNDER;
				end else if (opb_q == 32'd0) begin
					err = ERR_DIV0;
				end else begin
					div_go = 1'b1;
				end
			end
			CL_PRN, CL_NOT: begin
				if (sp_q == 9'd0) begin
					err = ERR_UNDER;
				end else begin
					sp_n = sp_q - 9'd1;
					if (cur_q.cls == CL_PRN) begin
						res_x.print_kind  = PK_NUM;
						res_x.print_value = opb_q;
					end else begin
						acc_n = {31'd0, opb_q == 32'd0};
					end
				end
			end
			CL_NL:    res_x.print_kind = PK_NL;
			CL_RDN:   acc_n = cur_q.cons;
			CL_UNSUP: err = ERR_UNSUP;
			CL_CALL: begin
				if (sp_q >= 9'(DS_DEPTH) || rsp_q >= 7'(RS_DEPTH)) begin
					err = ERR_OVER;
				end else begin
					ds_we_x = 1'b1;
					ds_wd   = {23'd0, fb_q};
					rs_we_x = 1'b1;
					sp_n    = sp_q + 9'd1;
					fb_n    = sp_q + 9'd1;
					rsp_n   = rsp_q + 7'd1;
					npc     = tgt;
				end
			end
			CL_RET: begin
				if (rsp_q == 7'd0 || fb_q == 9'd0) begin
					err = ERR_UNDER;
				end else if (opb_q[31] || opb_q > 32'(DS_DEPTH)) begin
					err = ERR_INDEX;
				end else begin
					rsp_n = rsp_q - 7'd1;
					npc   = rs_rd_q;
					sp_n  = fb_q - 9'd1;
					fb_n  = opb_q[SP_W-1:0];
				end
			end
			CL_HALT: begin
				halt_n          = 1'b1;
				res_x.exit_code = cur_q.xbyte;
				npc             = pc2;
			end
			CL_PUSH: begin
				if (sp_q >= 9'(DS_DEPTH)) begin
					err = ERR_OVER;
				end else begin
					ds_we_x = 1'b1;
					sp_n    = sp_q + 9'd1;
					npc     = pc1;
				end
			end
			CL_POP, CL_DISC: begin
				if (sp_q == 9'd0) begin
					err = ERR_UNDER;
				end else begin
					if (cur_q.cls == CL_POP) begin
						acc_n = opb_q;
					end
					sp_n = sp_q - 9'd1;
					npc  = pc1;
				end
			end
			CL_FLD, CL_FST: begin
				if (idx_bad) begin
					err = ERR_INDEX;
				end else if (cur_q.cls == CL_FLD) begin
					acc_n = opb_q;
				end else begin
					ds_we_x = 1'b1;
					ds_wa   = idx[DS_AW-1:0];
				end
			end
			CL_IMM: acc_n = cur_q.word;
			CL_MLD: acc_n = cur_q.load;
			CL_MST: begin
				res_x.mem_write = 1'b1;
				res_x.mem_addr  = tgt;
				res_x.mem_data  = acc_q;
			end
			CL_JZ:   npc = (acc_q != 32'd0) ? pc5 : tgt;
			CL_JMP:  npc = tgt;
			CL_JNZ:  npc = (acc_q == 32'd0) ? pc5 : tgt;
			default: err = ERR_OPC;
		endcase
		// An error leaves state alone and stops the machine at this instruction.
		if (err != ERR_OK) begin
			res_x      = '0;
			npc        = pc_q;
			halt_n     = 1'b1;
			res_x.error_code = err;
		end
		res_x.next_pc = npc;
		res_x.halted  = halt_n;
	end

	assign ds_we = (state_q == ST_EXE) && ds_we_x && (err == ERR_OK);
	assign rs_we = (state_q == ST_EXE) && rs_we_x && (err == ERR_OK);

	// Result of an item that arrives after the machine stopped, and of a finished divide.
	always_comb begin
		res_stop         = '0;
		res_stop.next_pc = pc_q;
		res_stop.halted  = 1'b1;
		res_div          = '0;
		res_div.next_pc  = pc5;
	end

	// Stack memories with registered reads.
	always_ff @(posedge clk) begin
		if (ds_we) begin
			ds_mem[ds_wa] <= ds_wd;
		end
		ds_rd_q <= ds_mem[ds_raddr];
		if (rs_we) begin
			rs_mem[RS_AW'(rsp_q)] <= pc5;
		end
		rs_rd_q <= rs_mem[rs_raddr];
	end

	sbx_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go && (state_q == ST_EXE)),
		.a      (opa_q),
		.b      (opb_q),
		.done   (div_done),
		.quot   (quot),
		.rem    (rem)
	);

	// Sequencer, machine state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cur_q     <= '0;
			acc_q     <= 32'd0;
			opa_q     <= 32'd0;
			opb_q     <= 32'd0;
			pc_q      <= '0;
			fb_q      <= '0;
			sp_q      <= '0;
			rsp_q     <= '0;
			stop_q    <= 1'b0;
			res_q     <= '0;
			res_vld_q <= 1'b0;
		end else begin
			if (pop && res_vld_q) begin
				res_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cur_q <= q_item;
						if (stop_q) begin
							res_q     <= res_stop;
							res_vld_q <= 1'b1;
						end else if (reads_of(q_item.cls) == 2'd0) begin
							state_q <= ST_EXE;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					opb_q   <= ds_rd_q;
					state_q <= (reads_of(cur_q.cls) == 2'd2) ? ST_RD2 : ST_EXE;
				end
				ST_RD2: begin
					opa_q   <= ds_rd_q;
					state_q <= ST_EXE;
				end
				ST_EXE: begin
					if (div_go) begin
						state_q <= ST_DIV;
					end else begin
						if (err == ERR_OK) begin
							acc_q <= acc_n;
							sp_q  <= sp_n;
							fb_q  <= fb_n;
							rsp_q <= rsp_n;
						end
						pc_q      <= npc;
						stop_q    <= halt_n;
						res_q     <= res_x;
						res_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						acc_q     <= (cur_q.cls == CL_MOD) ? rem : quot;
						sp_q      <= sp_q - 9'd2;
						pc_q      <= pc5;
						res_q     <= res_div;
						res_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/sbx_checker.sv =====
// Port assertions for the stack bytecode execute unit, with their bind.
`default_nettype none
module sbx_port_assert (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          push,
	input wire logic          full,
	input wire logic          empty,
	input wire logic          pop,
	input wire sbx_pkg::res_t res
);
	import sbx_pkg::*;

	// An error always stops the machine.
	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && res.error_code != ERR_OK) |-> res.halted)
		else $error("error result without halted");

	// A store and a print never come with an error.
	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && res.error_code != ERR_OK) |-> (!res.mem_write && res.print_kind == PK_NONE))
		else $error("error result with side effect");

	// Store fields and print value are zero when nothing is stored and no number prints.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !res.mem_write && res.print_kind != PK_NUM) |->
		(res.mem_addr == 16'd0 && res.mem_data == 32'sd0 && res.print_value == 32'sd0))
		else $error("unused result fields not zero");

	// A waiting result holds until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(res)))
		else $error("waiting result changed");

	// The input side can only fill up when an item arrives.
	a_full_rise: assert property (@(posedge clk) disable iff (!arst_n)
		(!push && !full) |=> !full)
		else $error("full without an incoming item");

endmodule

bind stack_bytecode_execute_unit sbx_port_assert u_sbx_port_assert (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.res    (res)
);
`default_nettype wire

// ===== tb/sbx_checker.sv =====
// Result checker for the stack bytecode execute unit: predicts each result and compares it.
`timescale 1ns / 100ps
`default_nettype none
module sbx_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic          full,
	input  wire sbx_pkg::req_t req,
	input  wire logic          empty,
	input  wire logic          pop,
	input  wire sbx_pkg::res_t res,
	output int                 fails,
	output int                 pending
);
	import sbx_pkg::*;

	// Predicted machine state.
	logic [31:0] acc;
	logic [15:0] pc;
	int          fbase;
	logic [31:0] dstk [DS_DEPTH];
	int          dsp;
	logic [15:0] rstk [RS_DEPTH];
	int          rsp;
	logic        stopped;
	res_t        expected_results [$];

	// Executes one instruction on the predicted state and returns its result.
	function automatic res_t exec_instr(req_t r);
		res_t        o;
		logic [2:0]  err;
		logic [15:0] nxt;
		longint      w, k, a, b, idx, sv;
		o = '0;
		err = ERR_OK;
		nxt = pc;
		w = r.operand_word;
		if (stopped) begin
			o.next_pc = pc;
			o.halted = 1'b1;
			return o;
		end
		case (r.req_type)
			OP_CALL: begin
				if (w < 0) begin
					k = -w;
					case (k)
						IN_ADD, IN_SUB, IN_DIV, IN_MUL, IN_MOD, IN_EQ, IN_LT, IN_GT: begin
							if (dsp < 2) begin
								err = ERR_UNDER;
							end else begin
								a = $signed(dstk[dsp-2]);
								b = $signed(dstk[dsp-1]);
								if ((k == IN_DIV || k == IN_MOD) && b == 0) begin
									err = ERR_DIV0;
								end else begin
									case (k)
										IN_ADD: acc = 32'(a + b);
										IN_SUB: acc = 32'(a - b);
										IN_DIV: acc = 32'(a / b);
										IN_MUL: acc = 32'(a * b);
										IN_MOD: acc = 32'(a % b);
										IN_EQ:  acc = (a == b) ? 32'd1 : 32'd0;
										IN_LT:  acc = (a < b) ? 32'd1 : 32'd0;
										default: acc = (a > b) ? 32'd1 : 32'd0;
									endcase
									dsp = dsp - 2;
								end
							end
						end
						IN_PRN, IN_NOT: begin
							if (dsp < 1) begin
								err = ERR_UNDER;
							end else begin
								if (k == IN_PRN) begin
									o.print_kind = PK_NUM;
									o.print_value = dstk[dsp-1];
								end else begin
									acc = (dstk[dsp-1] == 0) ? 32'd1 : 32'd0;
								end
								dsp = dsp - 1;
							end
						end
						IN_NL:  o.print_kind = PK_NL;
						IN_RDN: acc = r.console_number;
						default: err = ERR_UNSUP;
					endcase
					nxt = pc + 16'd5;
				end else if (dsp >= DS_DEPTH || rsp >= RS_DEPTH) begin
					err = ERR_OVER;
				end else begin
					dstk[dsp] = 32'(fbase);
					dsp = dsp + 1;
					fbase = dsp;
					rstk[rsp] = pc + 16'd5;
					rsp = rsp + 1;
					nxt = r.operand_word[15:0];
				end
			end
			OP_RET: begin
				if (rsp == 0 || fbase == 0) begin
					err = ERR_UNDER;
				end else begin
					sv = $signed(dstk[fbase-1]);
					if (sv < 0 || sv > DS_DEPTH) begin
						err = ERR_INDEX;
					end else begin
						rsp = rsp - 1;
						nxt = rstk[rsp];
						dsp = fbase - 1;
						fbase = int'(sv);
					end
				end
			end
			OP_HALT: begin
				o.halted = 1'b1;
				o.exit_code = r.operand_byte;
				stopped = 1'b1;
				nxt = pc + 16'd2;
			end
			OP_PUSH: begin
				if (dsp >= DS_DEPTH) begin
					err = ERR_OVER;
				end else begin
					dstk[dsp] = acc;
					dsp = dsp + 1;
					nxt = pc + 16'd1;
				end
			end
			OP_POP, OP_DISC: begin
				if (dsp == 0) begin
					err = ERR_UNDER;
				end else begin
					if (r.req_type == OP_POP)
						acc = dstk[dsp-1];
					dsp = dsp - 1;
					nxt = pc + 16'd1;
				end
			end
			OP_FLD, OP_FST: begin
				idx = fbase + w - 1;
				if (idx < 0 || idx >= DS_DEPTH) begin
					err = ERR_INDEX;
				end else begin
					if (r.req_type == OP_FLD)
						acc = dstk[idx];
					else
						dstk[idx] = acc;
					nxt = pc + 16'd5;
				end
			end
			OP_IMM: begin
				acc = r.operand_word;
				nxt = pc + 16'd5;
			end
			OP_MLD: begin
				acc = r.load_word;
				nxt = pc + 16'd5;
			end
			OP_MST: begin
				o.mem_write = 1'b1;
				o.mem_addr = r.operand_word[15:0];
				o.mem_data = acc;
				nxt = pc + 16'd5;
			end
			OP_JZ:  nxt = (acc != 0) ? pc + 16'd5 : r.operand_word[15:0];
			OP_JMP: nxt = r.operand_word[15:0];
			OP_JNZ: nxt = (acc == 0) ? pc + 16'd5 : r.operand_word[15:0];
			default: err = ERR_OPC;
		endcase
		if (err != ERR_OK) begin
			stopped = 1'b1;
			o = '0;
			o.halted = 1'b1;
			o.error_code = err;
			nxt = pc;
		end
		pc = nxt;
		o.next_pc = pc;
		return o;
	endfunction

	// Reports one field that differs from its prediction.
	task automatic check_field(string nm, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, nm, e, a);
			fails++;
		end
	endtask

	// Predict on every accepted item and compare every accepted result.
	always @(posedge clk or negedge arst_n) begin
		res_t e;
		if (!arst_n) begin
			acc = '0;
			pc = '0;
			fbase = 0;
			dsp = 0;
			rsp = 0;
			stopped = 1'b0;
			fails = 0;
			expected_results.delete();
		end else begin
			if (push && !full)
				expected_results.push_back(exec_instr(req));
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, actual %h", $time, res);
					fails++;
				end else begin
					e = expected_results.pop_front();
					check_field("next_pc", e.next_pc, res.next_pc);
					check_field("mem_write", e.mem_write, res.mem_write);
					check_field("mem_addr", e.mem_addr, res.mem_addr);
					check_field("mem_data", e.mem_data, res.mem_data);
					check_field("print_kind", e.print_kind, res.print_kind);
					check_field("print_value", e.print_value, res.print_value);
					check_field("halted", e.halted, res.halted);
					check_field("exit_code", e.exit_code, res.exit_code);
					check_field("error_code", e.error_code, res.error_code);
				end
			end
		end
		pending = expected_results.size();
	end

endmodule
`default_nettype wire

// ===== tb/stack_bytecode_execute_unit_tb.sv =====
// Stimulus and verdict for the stack bytecode execute unit testbench.
`timescale 1ns / 100ps
`default_nettype none
module stack_bytecode_execute_unit_tb;
	import sbx_pkg::*;

	localparam int N_RANDOM = 1350;
	localparam int LIMIT    = 1500000;

	logic clk, arst_n, push, pop, full, empty;
	req_t req;
	res_t res;
	int   fails, pending, cycles;
	bit   calm;

	// Shadow of the stack depths, kept so that only entries already written are read.
	int sp, fb, rsp;
	int saved_frames [$];

	stack_bytecode_execute_unit u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.empty(empty), .pop(pop), .res(res)
	);

	sbx_checker u_checker (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.empty(empty), .pop(pop), .res(res), .fails(fails), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Cycle limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Gap length: mostly none or short, a few long, none at all in calm stretches.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Result side: pop with random stalls.
	initial begin
		int gap;
		gap = 0;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				gap = gap_len();
			if (gap > 0) begin
				pop <= 1'b0;
				gap--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Sends one item and waits until it is accepted, then idles for a random gap.
	task automatic send(req_t r);
		int g;
		req <= r;
		push <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		g = gap_len();
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Sends an instruction with random side fields and tracks the stack depths.
	task automatic issue(logic [7:0] op, logic [31:0] w);
		req_t   r;
		longint k;
		r.req_type = op;
		r.operand_word = w;
		r.operand_byte = 8'($urandom);
		r.load_word = $urandom;
		r.console_number = $urandom;
		send(r);
		k = -longint'($signed(w));
		case (op)
			OP_CALL: begin
				if ($signed(w) >= 0) begin
					saved_frames.push_back(fb);
					sp++;
					fb = sp;
					rsp++;
				end else if (k == IN_PRN || k == IN_NOT) begin
					sp--;
				end else if (k != IN_NL && k != IN_RDN) begin
					sp -= 2;
				end
			end
			OP_RET: begin
				sp = fb - 1;
				fb = saved_frames.pop_back();
				rsp--;
			end
			OP_PUSH: sp++;
			OP_POP, OP_DISC: sp--;
			default: ;
		endcase
	endtask

	// Divide or modulo on two freshly pushed operands with a nonzero divisor.
	task automatic div_seq(logic [31:0] a, logic [31:0] b, bit modulo);
		issue(OP_IMM, a);
		issue(OP_PUSH, $urandom);
		issue(OP_IMM, b);
		issue(OP_PUSH, $urandom);
		issue(OP_CALL, modulo ? -IN_MOD : -IN_DIV);
	endtask

	// One random legal instruction or short sequence.
	task automatic rand_instr();
		bit          done;
		int          idx;
		logic [31:0] d;
		done = 0;
		while (!done) begin
			done = 1;
			case ($urandom_range(0, 15))
				0: if (sp < 250) issue(OP_PUSH, $urandom); else done = 0;
				1: if (sp > fb) issue(OP_POP, $urandom); else done = 0;
				2: if (sp > fb) issue(OP_DISC, $urandom); else done = 0;
				3: issue(OP_IMM, $urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : $urandom);
				4: issue(OP_MLD, $urandom);
				5: issue(OP_MST, $urandom);
				6: issue(OP_JZ, $urandom);
				7: issue(OP_JNZ, $urandom);
				8: issue(OP_JMP, $urandom);
				9: begin
					if (sp > 0) begin
						idx = $urandom_range(0, sp - 1);
						issue(OP_FLD, idx - fb + 1);
					end else done = 0;
				end
				10: begin
					if (sp > fb) begin
						idx = $urandom_range(fb, sp - 1);
						issue(OP_FST, idx - fb + 1);
					end else done = 0;
				end
				11: begin
					if (sp < 250 && rsp < 60)
						issue(OP_CALL, $urandom & 32'h7fff_ffff);
					else done = 0;
				end
				12: if (rsp > 0) issue(OP_RET, $urandom); else done = 0;
				13: begin
					if (sp - fb >= 2) begin
						case ($urandom_range(0, 5))
							0: issue(OP_CALL, -IN_ADD);
							1: issue(OP_CALL, -IN_SUB);
							2: issue(OP_CALL, -IN_MUL);
							3: issue(OP_CALL, -IN_EQ);
							4: issue(OP_CALL, -IN_LT);
							default: issue(OP_CALL, -IN_GT);
						endcase
					end else done = 0;
				end
				14: begin
					if (sp <= 248) begin
						d = $urandom;
						if (d == 0 || $urandom_range(0, 9) == 0)
							d = 32'hffff_ffff;
						div_seq($urandom_range(0, 9) == 0 ? 32'h8000_0000 : $urandom, d,
							1'($urandom_range(0, 1)));
					end else done = 0;
				end
				default: begin
					case ($urandom_range(0, 3))
						0: if (sp > fb) issue(OP_CALL, -IN_PRN); else done = 0;
						1: if (sp > fb) issue(OP_CALL, -IN_NOT); else done = 0;
						2: issue(OP_CALL, -IN_NL);
						default: issue(OP_CALL, -IN_RDN);
					endcase
				end
			endcase
		end
	endtask

	// Stimulus and verdict.
	initial begin
		req_t r;
		int   i;
		push = 1'b0;
		req = '0;
		calm = 1'b0;
		cycles = 0;
		sp = 0;
		fb = 0;
		rsp = 0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: wrapping add, minimum by minus one, and a selection of other opcodes and intrinsics.
		issue(OP_IMM, 32'h7fff_ffff);
		issue(OP_PUSH, 0);
		issue(OP_IMM, 1);
		issue(OP_PUSH, 0);
		issue(OP_CALL, -IN_ADD);
		div_seq(32'h8000_0000, 32'hffff_ffff, 0);
		div_seq(32'h8000_0000, 32'hffff_ffff, 1);
		div_seq(32'hffff_fff9, 2, 0);
		issue(OP_MST, 32'hffff_ffff);
		issue(OP_JZ, 32'h1234);
		issue(OP_JNZ, 32'h8000_0000);
		issue(OP_CALL, 32'h7fff_ffff);
		issue(OP_PUSH, 0);
		issue(OP_FST, 1);
		issue(OP_FLD, 0);
		issue(OP_CALL, -IN_NOT);
		issue(OP_RET, 0);
		issue(OP_CALL, -IN_RDN);
		issue(OP_CALL, -IN_NL);
		issue(OP_MLD, 32'h8000_0000);
		issue(OP_PUSH, 0);
		issue(OP_CALL, -IN_PRN);
		issue(OP_JMP, 32'hffff_fffe);

		// Random programs, with calm stretches and one drain in the middle.
		for (i = 0; i < N_RANDOM; i++) begin
			calm = ((i / 150) % 4) == 3;
			if (i == N_RANDOM / 2) begin
				push <= 1'b0;
				@(negedge clk);
				while (pending != 0)
					@(negedge clk);
				@(posedge clk);
			end
			rand_instr();
		end
		calm = 1'b0;

		// Unwind, then stop the machine in one of its halting ways.
		while (rsp > 0)
			issue(OP_RET, 0);
		while (sp > 0)
			issue(OP_DISC, 0);
		case ($urandom_range(0, 6))
			0: issue(OP_HALT, $urandom);
			1: issue(8'($urandom_range(14, 255)), $urandom);
			2: issue(OP_CALL, $urandom_range(0, 1) ? -$urandom_range(10, 21)
				: 32'h8000_0000 | $urandom_range(0, 32'h7fff_ffe6));
			3: repeat (DS_DEPTH + 1) issue(OP_PUSH, $urandom);
			4: issue($urandom_range(0, 1) ? OP_POP : OP_RET, $urandom);
			5: begin
				issue(OP_IMM, $urandom);
				issue(OP_PUSH, 0);
				issue(OP_IMM, 0);
				issue(OP_PUSH, 0);
				issue(OP_CALL, $urandom_range(0, 1) ? -IN_DIV : -IN_MOD);
			end
			default: issue($urandom_range(0, 1) ? OP_FLD : OP_FST,
				$urandom_range(0, 1) ? -$urandom_range(0, 1000) : $urandom_range(257, 5000));
		endcase

		// The stopped machine ignores whatever follows.
		repeat (24) begin
			r = $bits(req_t)'({$urandom, $urandom, $urandom, $urandom});
			send(r);
		end
		push <= 1'b0;

		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (60) @(posedge clk);
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire
